FILE: hw/rtl/oahs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// oahs_pkg: shared definitions for the open-addressed handle set
// Field widths, hash constants, table size default and result status codes.
// ----------------------------------------------------------------------------
package oahs_pkg;

    // Default table size in slots (power of two)
    localparam int TABLE_SLOTS_DEF = 1024;

    // Fibonacci hash: wrapped 64-bit product, shifted right, then masked
    localparam logic [63:0] HASH_MULT  = 64'h9E37_79B9_7F4A_7C15;
    localparam int          HASH_SHIFT = 32;

    // Payload field widths
    localparam int KIND_W   = 1;
    localparam int HANDLE_W = 64;
    localparam int STATUS_W = 3;
    localparam int LIVE_W   = 10;
    localparam int STRAY_W  = 32;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_ACQUIRE = 1'b0;
    localparam logic [KIND_W-1:0] KIND_CONSUME = 1'b1;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 3'd0,
        ST_ALREADY  = 3'd1,
        ST_RELEASED = 3'd2,
        ST_STRAY    = 3'd3,
        ST_NULL     = 3'd4,
        ST_FULL     = 3'd5
    } status_t;

endpackage
`default_nettype wire

FILE: hw/rtl/open_addressed_handle_set_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// open_addressed_handle_set_unit: set of live 64-bit handles
// Linear-probing hash set with backward-shift deletion in one table RAM.
// ----------------------------------------------------------------------------
// After reset the block sweeps the table to empty, one slot a cycle, and
// takes no item meanwhile. It then works on one item at a time. A null
// handle is accepted and goes straight to the result. Any other item is
// accepted, passes through the shared hash unit (one 32x32 multiplier over
// three partial products, then the home slot is flagged), then probes slots
// through the single table read port, each slot read and then checked, and
// then posts the result. A release also scans the run after the freed slot
// up to the empty slot that ends it; each occupied slot in the run is
// rehashed and possibly moved back. A long cluster stretches an item in
// proportion to the slots it walks. The block stays in its result state while
// the output register still holds an earlier item that has not been taken.
// A finished result waits in the output register while the next item is
// accepted.
// ----------------------------------------------------------------------------
module open_addressed_handle_set_unit #(
    parameter int TABLE_SLOTS = oahs_pkg::TABLE_SLOTS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [oahs_pkg::KIND_W-1:0]   s_kind,
    input  wire logic [oahs_pkg::HANDLE_W-1:0] s_handle,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic      [oahs_pkg::STATUS_W-1:0] m_status,
    output logic      [oahs_pkg::LIVE_W-1:0]   m_live_count,
    output logic      [oahs_pkg::STRAY_W-1:0]  m_stray_count,
    output logic      [oahs_pkg::HANDLE_W-1:0] m_stray_addr
);
    import oahs_pkg::*;

    localparam int SLOT_BITS = $clog2(TABLE_SLOTS);
    localparam int CNT_W     = SLOT_BITS;

    typedef enum logic [9:0] {
        S_CLEAR     = 10'b00_0000_0001,
        S_IDLE      = 10'b00_0000_0010,
        S_HASH      = 10'b00_0000_0100,
        S_PROBE_RD  = 10'b00_0000_1000,
        S_PROBE_CHK = 10'b00_0001_0000,
        S_SCAN_RD   = 10'b00_0010_0000,
        S_SCAN_CHK  = 10'b00_0100_0000,
        S_SCAN_HASH = 10'b00_1000_0000,
        S_SCAN_MOVE = 10'b01_0000_0000,
        S_RESULT    = 10'b10_0000_0000
    } state_t;

    state_t               state_reg,  state_next;
    logic [KIND_W-1:0]    kind_reg,   kind_next;
    logic [HANDLE_W-1:0]  handle_reg, handle_next;
    logic [SLOT_BITS-1:0] pos_reg,    pos_next;
    logic [SLOT_BITS-1:0] scan_reg,   scan_next;
    logic [SLOT_BITS-1:0] clr_reg,    clr_next;
    logic [HANDLE_W-1:0]  entry_reg,  entry_next;
    status_t              status_reg, status_next;
    logic [CNT_W-1:0]     live_reg,   live_next;
    logic [STRAY_W-1:0]   stray_reg,  stray_next;
    logic [HANDLE_W-1:0]  first_reg,  first_next;

    logic                 m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0]  m_status_reg, m_status_next;
    logic [LIVE_W-1:0]    m_live_reg,   m_live_next;
    logic [STRAY_W-1:0]   m_stray_reg,  m_stray_next;
    logic [HANDLE_W-1:0]  m_first_reg,  m_first_next;

    logic                 ram_we;
    logic [SLOT_BITS-1:0] ram_waddr;
    logic [HANDLE_W-1:0]  ram_wdata;
    logic [SLOT_BITS-1:0] ram_raddr;
    logic [HANDLE_W-1:0]  ram_rdata;

    logic                 hash_start;
    logic [HANDLE_W-1:0]  hash_key;
    logic                 hash_done;
    logic [SLOT_BITS-1:0] hash_home;

    logic [SLOT_BITS-1:0] dist_hole, dist_home;
    logic [CNT_W+LIVE_W-1:0] live_wide;
    logic                 s_fire;

    oahs_ram #(
        .WIDTH (HANDLE_W),
        .DEPTH (TABLE_SLOTS)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    oahs_hash #(
        .SLOT_BITS (SLOT_BITS)
    ) u_hash (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (hash_start),
        .key     (hash_key),
        .done    (hash_done),
        .home    (hash_home)
    );

    assign s_ready  = (state_reg == S_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign hash_key = (state_reg == S_IDLE) ? s_handle : ram_rdata;
    assign ram_raddr = (state_reg == S_SCAN_RD) ? scan_reg : pos_reg;

    // Wrapped distances for the backward-shift test
    assign dist_hole = scan_reg - pos_reg;
    assign dist_home = scan_reg - hash_home;

    // Live count seen through the 10-bit field
    assign live_wide = {{LIVE_W{1'b0}}, live_reg};

    // Sequencer
    always_comb begin
        state_next  = state_reg;
        kind_next   = kind_reg;
        handle_next = handle_reg;
        pos_next    = pos_reg;
        scan_next   = scan_reg;
        clr_next    = clr_reg;
        entry_next  = entry_reg;
        status_next = status_reg;
        live_next   = live_reg;
        stray_next  = stray_reg;
        first_next  = first_reg;
        ram_we      = 1'b0;
        ram_waddr   = pos_reg;
        ram_wdata   = '0;
        hash_start  = 1'b0;

        m_valid_next  = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        m_live_next   = m_live_reg;
        m_stray_next  = m_stray_reg;
        m_first_next  = m_first_reg;

        case (state_reg)
            // Sweep the table to empty
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                clr_next  = clr_reg + SLOT_BITS'(1);
                if (clr_reg == {SLOT_BITS{1'b1}}) begin
                    state_next = S_IDLE;
                end
            end
            // Take an item; drop a null handle at once
            S_IDLE: begin
                if (s_fire) begin
                    kind_next   = s_kind;
                    handle_next = s_handle;
                    if (s_handle == '0) begin
                        status_next = ST_NULL;
                        state_next  = S_RESULT;
                    end else begin
                        hash_start = 1'b1;
                        state_next = S_HASH;
                    end
                end
            end
            // Wait for the home slot
            S_HASH: begin
                if (hash_done) begin
                    pos_next   = hash_home;
                    state_next = S_PROBE_RD;
                end
            end
            S_PROBE_RD: begin
                state_next = S_PROBE_CHK;
            end
            // Resolve the probe: match, empty slot, or advance
            S_PROBE_CHK: begin
                if (ram_rdata == handle_reg) begin
                    if (kind_reg == KIND_ACQUIRE) begin
                        status_next = ST_ALREADY;
                        state_next  = S_RESULT;
                    end else begin
                        ram_we     = 1'b1;
                        ram_wdata  = '0;
                        scan_next  = pos_reg + SLOT_BITS'(1);
                        state_next = S_SCAN_RD;
                    end
                end else if (ram_rdata == '0) begin
                    if (kind_reg == KIND_ACQUIRE) begin
                        if (live_reg >= CNT_W'(TABLE_SLOTS / 2)) begin
                            status_next = ST_FULL;
                        end else begin
                            ram_we      = 1'b1;
                            ram_wdata   = handle_reg;
                            live_next   = live_reg + CNT_W'(1);
                            status_next = ST_INSERTED;
                        end
                    end else begin
                        if (stray_reg != {STRAY_W{1'b1}}) begin
                            stray_next = stray_reg + STRAY_W'(1);
                        end
                        if (first_reg == '0) begin
                            first_next = handle_reg;
                        end
                        status_next = ST_STRAY;
                    end
                    state_next = S_RESULT;
                end else begin
                    pos_next   = pos_reg + SLOT_BITS'(1);
                    state_next = S_PROBE_RD;
                end
            end
            S_SCAN_RD: begin
                state_next = S_SCAN_CHK;
            end
            // End the run at an empty slot, else rehash the entry
            S_SCAN_CHK: begin
                if (ram_rdata == '0) begin
                    if (live_reg != '0) begin
                        live_next = live_reg - CNT_W'(1);
                    end
                    status_next = ST_RELEASED;
                    state_next  = S_RESULT;
                end else begin
                    entry_next = ram_rdata;
                    hash_start = 1'b1;
                    state_next = S_SCAN_HASH;
                end
            end
            // Move the entry into the hole if its home allows it
            S_SCAN_HASH: begin
                if (hash_done) begin
                    if (dist_home >= dist_hole) begin
                        ram_we     = 1'b1;
                        ram_waddr  = pos_reg;
                        ram_wdata  = entry_reg;
                        state_next = S_SCAN_MOVE;
                    end else begin
                        scan_next  = scan_reg + SLOT_BITS'(1);
                        state_next = S_SCAN_RD;
                    end
                end
            end
            // Empty the old slot; it becomes the hole
            S_SCAN_MOVE: begin
                ram_we     = 1'b1;
                ram_waddr  = scan_reg;
                ram_wdata  = '0;
                pos_next   = scan_reg;
                scan_next  = scan_reg + SLOT_BITS'(1);
                state_next = S_SCAN_RD;
            end
            // Post the result once the output register is free
            S_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_live_next   = live_wide[LIVE_W-1:0];
                    m_stray_next  = stray_reg;
                    m_first_next  = first_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            live_reg    <= '0;
            stray_reg   <= '0;
            first_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            live_reg    <= live_next;
            stray_reg   <= stray_next;
            first_reg   <= first_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload and work registers
    always_ff @(posedge aclk) begin
        kind_reg     <= kind_next;
        handle_reg   <= handle_next;
        pos_reg      <= pos_next;
        scan_reg     <= scan_next;
        entry_reg    <= entry_next;
        status_reg   <= status_next;
        m_status_reg <= m_status_next;
        m_live_reg   <= m_live_next;
        m_stray_reg  <= m_stray_next;
        m_first_reg  <= m_first_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_live_count  = m_live_reg;
    assign m_stray_count = m_stray_reg;
    assign m_stray_addr  = m_first_reg;

    // The table never holds more than half its slots
    a_live_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        live_reg <= CNT_W'(TABLE_SLOTS / 2))
        else $error("live count above half the table");

    // The hash unit finishes only while the sequencer waits for it
    a_hash_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        hash_done |-> (state_reg == S_HASH || state_reg == S_SCAN_HASH))
        else $error("hash result with no one waiting");

    // A null handle goes straight to its result
    a_null_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_handle == '0) |=> (state_reg == S_RESULT && status_reg == ST_NULL))
        else $error("null item not dropped");

endmodule
`default_nettype wire

FILE: hw/rtl/oahs_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// oahs_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module oahs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and read, read data registered
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

FILE: hw/rtl/oahs_hash.sv
`default_nettype none
// ----------------------------------------------------------------------------
// oahs_hash: iterative Fibonacci hash unit
// Forms the home slot of a 64-bit key with one shared 32x32 multiplier over
// three partial-product steps; only the low 64 bits of the product are kept.
// ----------------------------------------------------------------------------
module oahs_hash #(
    parameter int SLOT_BITS = 10
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [oahs_pkg::HANDLE_W-1:0] key,
    output logic                               done,
    output logic      [SLOT_BITS-1:0]          home
);
    import oahs_pkg::*;

    // Partial product steps
    localparam logic [1:0] STEP_LL = 2'd0;
    localparam logic [1:0] STEP_LH = 2'd1;
    localparam logic [1:0] STEP_HL = 2'd2;

    logic [HANDLE_W-1:0] key_reg;
    logic [63:0]         acc_reg,  acc_next;
    logic [1:0]          step_reg, step_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [31:0]         op_a, op_b;
    logic [63:0]         prod;

    // Select the operand halves for this step
    always_comb begin
        case (step_reg)
            STEP_LL: begin
                op_a = key_reg[31:0];
                op_b = HASH_MULT[31:0];
            end
            STEP_LH: begin
                op_a = key_reg[31:0];
                op_b = HASH_MULT[63:32];
            end
            STEP_HL: begin
                op_a = key_reg[63:32];
                op_b = HASH_MULT[31:0];
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign prod = {32'd0, op_a} * {32'd0, op_b};

    // Accumulate partial products and step the counter
    always_comb begin
        acc_next  = acc_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            busy_next = 1'b1;
            step_next = STEP_LL;
        end else if (busy_reg) begin
            if (step_reg == STEP_LL) begin
                acc_next = prod;
            end else begin
                acc_next = acc_reg + {prod[31:0], 32'd0};
            end
            if (step_reg == STEP_HL) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                step_next = step_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= STEP_LL;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Hold the key and the running sum
    always_ff @(posedge aclk) begin
        if (start) begin
            key_reg <= key;
        end
        acc_reg <= acc_next;
    end

    assign done = done_reg;
    assign home = acc_reg[HASH_SHIFT +: SLOT_BITS];

endmodule
`default_nettype wire
